// ===== rtl/motion_packet_field_parser_unit_defines.svh =====
// Assertion helpers for the parser top level.
`ifndef MOTION_PACKET_FIELD_PARSER_UNIT_DEFINES_SVH
`define MOTION_PACKET_FIELD_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MPFP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpfp same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MPFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpfp next-cycle check failed");

`endif

// ===== rtl/mpfp_pkg.sv =====
package mpfp_pkg;

  localparam logic [7:0] MAGIC_BYTE = 8'hDE;
  localparam int unsigned SEC_BYTES_MAX = 12;
  localparam int unsigned FLAG_W = 5;

  typedef enum logic [2:0] {
    KIND_ACCEL    = 3'd0,
    KIND_BUTTONS  = 3'd1,
    KIND_POINTER  = 3'd2,
    KIND_NUNCHUCK = 3'd3,
    KIND_NUNACCEL = 3'd4,
    KIND_STATUS   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    HDR_MAGIC = 2'd0,
    HDR_SKIP  = 2'd1,
    HDR_FLAGS = 2'd2,
    HDR_BODY  = 2'd3
  } hdr_state_t;

  // Classified byte passed from front to back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       wr;
    logic [3:0] idx;
    logic       sec_vld;
    kind_t      sec;
    logic       stat_vld;
    logic       stat;
  } entry_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic [7:0]         nun_buttons;
    logic               status;
    logic               last_of_packet;
  } out_item_t;

  function automatic logic [3:0] sec_len(input kind_t k);
    logic [3:0] len;
    unique case (k)
      KIND_ACCEL:    len = 4'd12;
      KIND_BUTTONS:  len = 4'd4;
      KIND_POINTER:  len = 4'd8;
      KIND_NUNCHUCK: len = 4'd9;
      KIND_NUNACCEL: len = 4'd12;
      default:       len = 4'd12;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/mpfp_in_if.sv =====
interface mpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       packet_end;

  modport source (output valid, output data_byte, output packet_end, input ready);
  modport sink (input valid, input data_byte, input packet_end, output ready);
endinterface

// ===== rtl/mpfp_out_if.sv =====
interface mpfp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] value_a;
  logic signed [31:0] value_b;
  logic signed [31:0] value_c;
  logic [7:0]         nun_buttons;
  logic               status;
  logic               last_of_packet;

  modport source (output valid, output kind, output value_a, output value_b,
                  output value_c, output nun_buttons, output status,
                  output last_of_packet, input ready);
  modport sink (input valid, input kind, input value_a, input value_b,
                input value_c, input nun_buttons, input status,
                input last_of_packet, output ready);
endinterface

// ===== rtl/mpfp_front.sv =====
module mpfp_front
  import mpfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  mpfp_in_if.sink    in_ch,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  hdr_state_t         hdr_r, hdr_nxt;
  logic [FLAG_W-1:0]  pend_r, pend_nxt;
  logic [3:0]         cnt_r, cnt_nxt;
  logic               drop_r, drop_nxt;

  logic               acc;
  logic               body_wr;
  kind_t              cur_sec;
  logic [3:0]         cnt_inc;
  logic               sec_done;
  logic [FLAG_W-1:0]  pend_after;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && !q_full;
  assign push        = acc;

  // Lowest pending flag picks the section being gathered.
  always_comb begin
    priority if (pend_r[0]) cur_sec = KIND_ACCEL;
    else if (pend_r[1])     cur_sec = KIND_BUTTONS;
    else if (pend_r[2])     cur_sec = KIND_POINTER;
    else if (pend_r[3])     cur_sec = KIND_NUNCHUCK;
    else                    cur_sec = KIND_NUNACCEL;
  end

  assign body_wr  = !drop_r && (hdr_r == HDR_BODY) && (pend_r != '0);
  assign cnt_inc  = cnt_r + 4'd1;
  assign sec_done = body_wr && (cnt_inc >= sec_len(cur_sec));

  always_comb begin
    if (!drop_r && hdr_r == HDR_FLAGS) begin
      pend_after = in_ch.data_byte[FLAG_W-1:0];
    end else if (sec_done) begin
      pend_after = pend_r & ~(FLAG_W'(1) << cur_sec);
    end else begin
      pend_after = pend_r;
    end
  end

  // Next state.
  always_comb begin
    hdr_nxt  = hdr_r;
    pend_nxt = pend_after;
    cnt_nxt  = cnt_r;
    drop_nxt = drop_r;
    if (!drop_r) begin
      unique case (hdr_r)
        HDR_MAGIC: begin
          drop_nxt = (in_ch.data_byte != MAGIC_BYTE);
          hdr_nxt  = HDR_SKIP;
        end
        HDR_SKIP:  hdr_nxt = HDR_FLAGS;
        HDR_FLAGS: begin
          cnt_nxt = '0;
          hdr_nxt = HDR_BODY;
        end
        HDR_BODY: begin
          if (body_wr) begin
            cnt_nxt = sec_done ? 4'd0 : cnt_inc;
          end
        end
        default: hdr_nxt = HDR_MAGIC;
      endcase
    end
    if (in_ch.packet_end) begin
      hdr_nxt  = HDR_MAGIC;
      pend_nxt = '0;
      cnt_nxt  = '0;
      drop_nxt = 1'b0;
    end
  end

  // Classified transaction for the back end.
  always_comb begin
    push_entry.data_byte = in_ch.data_byte;
    push_entry.wr        = body_wr;
    push_entry.idx       = cnt_r;
    push_entry.sec_vld   = sec_done;
    push_entry.sec       = cur_sec;
    push_entry.stat_vld  = in_ch.packet_end;
    push_entry.stat      = drop_r || (hdr_r == HDR_MAGIC) || (hdr_r == HDR_SKIP) ||
                           (pend_after != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r  <= HDR_MAGIC;
      pend_r <= '0;
      cnt_r  <= '0;
      drop_r <= 1'b0;
    end else if (acc) begin
      hdr_r  <= hdr_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

// ===== rtl/mpfp_queue.sv =====
module mpfp_queue
  import mpfp_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_vld,
  output entry_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign head_vld = (cnt_r != '0);
  assign head     = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && head_vld;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + CNT_W'(1);
        2'b01:   cnt_r <= cnt_r - CNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/mpfp_back.sv =====
module mpfp_back
  import mpfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_vld,
  input  entry_t    head,
  output logic      pop,
  mpfp_out_if.source out_ch
);

  logic [7:0]  bytes_r [SEC_BYTES_MAX];
  logic [7:0]  view [SEC_BYTES_MAX];
  logic        phase_r, phase_nxt;
  logic        out_vld_r, out_vld_nxt;
  out_item_t   out_r, out_nxt;
  logic        can_load, load, two_items, needs_out;
  out_item_t   sec_item, stat_item;
  logic [31:0] w0, w1, w4, w5, w8;

  // Merge the incoming byte so a section completes in the same step.
  always_comb begin
    for (int i = 0; i < SEC_BYTES_MAX; i++) begin
      view[i] = (head.wr && head.idx == 4'(i)) ? head.data_byte : bytes_r[i];
    end
  end

  assign w0 = {view[0], view[1], view[2],  view[3]};
  assign w1 = {view[1], view[2], view[3],  view[4]};
  assign w4 = {view[4], view[5], view[6],  view[7]};
  assign w5 = {view[5], view[6], view[7],  view[8]};
  assign w8 = {view[8], view[9], view[10], view[11]};

  always_comb begin
    sec_item      = '0;
    sec_item.kind = head.sec;
    unique case (head.sec)
      KIND_BUTTONS: sec_item.value_a = w0;
      KIND_POINTER: begin
        sec_item.value_a = w0;
        sec_item.value_b = w4;
      end
      KIND_NUNCHUCK: begin
        sec_item.value_a     = w1;
        sec_item.value_b     = w5;
        sec_item.nun_buttons = view[0];
      end
      default: begin
        sec_item.value_a = w0;
        sec_item.value_b = w4;
        sec_item.value_c = w8;
      end
    endcase
  end

  always_comb begin
    stat_item                = '0;
    stat_item.kind           = KIND_STATUS;
    stat_item.status         = head.stat;
    stat_item.last_of_packet = 1'b1;
  end

  assign can_load  = !out_vld_r || out_ch.ready;
  assign two_items = head.sec_vld && head.stat_vld;
  assign needs_out = head.sec_vld || head.stat_vld;
  assign load      = head_vld && needs_out && can_load;
  // Hold the entry for a second step when it yields section then status.
  assign pop       = head_vld && (!needs_out || (can_load && (phase_r || !two_items)));

  always_comb begin
    phase_nxt   = phase_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    if (load) begin
      out_vld_nxt = 1'b1;
      if (head.sec_vld && !phase_r) begin
        out_nxt   = sec_item;
        phase_nxt = two_items;
      end else begin
        out_nxt   = stat_item;
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_vld && head.wr) begin
      bytes_r[head.idx] <= head.data_byte;
    end
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.kind           = out_r.kind;
  assign out_ch.value_a        = out_r.value_a;
  assign out_ch.value_b        = out_r.value_b;
  assign out_ch.value_c        = out_r.value_c;
  assign out_ch.nun_buttons    = out_r.nun_buttons;
  assign out_ch.status         = out_r.status;
  assign out_ch.last_of_packet = out_r.last_of_packet;

endmodule

// ===== rtl/motion_packet_field_parser_unit.sv =====
// Motion datagram parser: feed one datagram byte per transaction on in_ch, with
// packet_end set on the last byte. The front end checks the 0xDE magic, skips
// byte 1, latches the five section flags from byte 2 and tags every body byte
// with its section and offset. The back end collects the bytes and emits one
// out_ch transaction per completed section (accel, buttons, pointer, nunchuck,
// nunchuck accel; words big-endian, coordinates left as raw Q11.20), then a
// status transaction (last_of_packet set) on the final byte. A packet that is
// short, has a bad magic or ends inside a flagged section reports rejected;
// sections already sent stand, trailing bytes are dropped. Throughput is one
// byte per clock while the queue has room; a final byte that also completes
// a section yields two output transactions, absorbed by the QUEUE_DEPTH-entry
// queue between front and back. Results pass the queue and output register.
module motion_packet_field_parser_unit
  import mpfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  mpfp_in_if.sink    in_ch,
  mpfp_out_if.source out_ch
);

  `include "motion_packet_field_parser_unit_defines.svh"

  logic   q_push, q_full, q_pop, q_head_vld;
  entry_t q_push_entry, q_head;

  // Classify bytes and advance the header/section state.
  mpfp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // Decouple classification from result delivery.
  mpfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_vld   (q_head_vld),
    .head       (q_head)
  );

  // Assemble sections and drive the output register.
  mpfp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_vld (q_head_vld),
    .head     (q_head),
    .pop      (q_pop),
    .out_ch   (out_ch)
  );

  // Status transactions carry only the verdict and the end marker.
  `MPFP_ASSERT_NOW(a_status_shape, clk, rst_n, out_ch.valid && out_ch.kind == KIND_STATUS, out_ch.last_of_packet && out_ch.value_a == 0 && out_ch.nun_buttons == 0)
  // Section transactions never carry a verdict or end marker.
  `MPFP_ASSERT_NOW(a_section_shape, clk, rst_n, out_ch.valid && out_ch.kind != KIND_STATUS, !out_ch.status && !out_ch.last_of_packet)
  // An entry that yields section and status must not leave the queue early.
  `MPFP_ASSERT_NEXT(a_two_item_hold, clk, rst_n, q_head_vld && q_head.sec_vld && q_head.stat_vld && !q_pop, q_head_vld && q_head.stat_vld)

endmodule
